@@ rtl/cje_pkg.sv @@
// ----------------------------------------------------------------------------
// Cubic Julia escape-time package
// Shared widths, constants, item and control types for the escape-time block.
// ----------------------------------------------------------------------------
package cje_pkg;

  // Field widths of the items and registers.
  localparam int COORD_W   = 32;
  localparam int ITER_W    = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Fixed-point format: every value carries 28 fraction bits.
  localparam int FRAC_W = 28;
  // Internal signed values stay below 2^44 in magnitude for any input.
  localparam int VAL_W  = 48;
  // Multiplier operands stay below 2^38 in magnitude.
  localparam int MUL_W  = 40;
  localparam int DIG_W  = MUL_W / 2;
  localparam int PART_W = MUL_W + DIG_W;
  localparam int PROD_W = 2 * MUL_W;
  // Squares for the escape test are taken of components below ten.
  localparam int SQ_W   = 2 * COORD_W;
  localparam int NORM_W = SQ_W + 1;

  localparam logic [VAL_W-1:0]        ESC_COMP = VAL_W'(64'd10 << FRAC_W);
  localparam logic [NORM_W-1:0]       ESC_NORM = NORM_W'(64'd100 << (2 * FRAC_W));
  localparam logic signed [VAL_W-1:0] ONE_FX   = VAL_W'(64'd1 << FRAC_W);
  localparam logic [ITER_W-1:0]       MAX_ITER_RST = ITER_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_REAL   = 2'd0,
    CFG_A_IMAG   = 2'd1,
    CFG_MAX_ITER = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_re;
    logic signed [COORD_W-1:0] point_im;
  } in_item_t;

  typedef struct packed {
    logic [ITER_W-1:0] iter_count;
    logic              stayed_bounded;
  } out_item_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] a_real;
    logic signed [CFG_W-1:0] a_imag;
    logic [ITER_W-1:0]       max_iter;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] op_a;
    logic [MUL_W-1:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef enum logic [1:0] {
    M_IDLE,
    M_LO,
    M_HI,
    M_SUM
  } mul_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ISSUE,
    S_WAIT,
    S_DONE
  } seq_e;

  // One product of the escape test or of the cubic map.
  typedef enum logic [3:0] {
    ST_XRXR,
    ST_XIXI,
    ST_TRTR,
    ST_TITI,
    ST_TRTI,
    ST_SRUR,
    ST_SIUI,
    ST_SRUI,
    ST_SIUR
  } step_e;

  function automatic logic [VAL_W-1:0] mag(logic signed [VAL_W-1:0] v);
    mag = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
  endfunction

endpackage

@@ rtl/cje_mul.sv @@
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 40 x 40 product formed from two 40 x 20 partial products and a sum.
// ----------------------------------------------------------------------------
module cje_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cje_pkg::mul_req_t  req_i,
  output cje_pkg::mul_rsp_t  rsp_o
);
  import cje_pkg::*;

  mul_e phase_q, phase_d;
  logic [MUL_W-1:0]  a_q, b_q;
  logic [DIG_W-1:0]  dig;
  logic [PART_W-1:0] part;
  logic [PART_W-1:0] lo_q, hi_q;
  logic [PROD_W-1:0] prod_q;
  logic              done_q, done_d;

  assign dig  = (phase_q == M_LO) ? b_q[DIG_W-1:0] : b_q[MUL_W-1:DIG_W];
  assign part = PART_W'(a_q * dig);

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    unique case (phase_q)
      M_IDLE: begin
        if (req_i.start) begin
          phase_d = M_LO;
        end
      end
      M_LO:  phase_d = M_HI;
      M_HI:  phase_d = M_SUM;
      M_SUM: begin
        phase_d = M_IDLE;
        done_d  = 1'b1;
      end
      default: phase_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == M_IDLE && req_i.start) begin
      a_q <= req_i.op_a;
      b_q <= req_i.op_b;
    end
    if (phase_q == M_LO) begin
      lo_q <= part;
    end
    if (phase_q == M_HI) begin
      hi_q <= part;
    end
    if (phase_q == M_SUM) begin
      prod_q <= PROD_W'(lo_q) + {hi_q, {DIG_W{1'b0}}};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

endmodule

@@ rtl/cje_seq.sv @@
// ----------------------------------------------------------------------------
// Escape-time sequencer
// Steps one point through the escape test and the cubic map on the shared
// multiplier, and holds the finished item in an output register.
// ----------------------------------------------------------------------------
module cje_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cje_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cje_pkg::out_item_t out_data_o,
  input  cje_pkg::cfg_t      cfg_i,
  output cje_pkg::mul_req_t  mul_req_o,
  input  cje_pkg::mul_rsp_t  mul_rsp_i
);
  import cje_pkg::*;

  seq_e  state_q, state_d;
  step_e step_q, step_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic signed [VAL_W-1:0] xr_q, xr_d, xi_q, xi_d;
  logic signed [VAL_W-1:0] tr_q, tr_d, ti_q, ti_d;
  logic signed [VAL_W-1:0] ur_q, ur_d, ui_q, ui_d;
  logic signed [VAL_W-1:0] sr_q, sr_d, si_q, si_d;
  logic signed [VAL_W-1:0] accr_q, accr_d, acci_q, acci_d;
  logic [NORM_W-1:0] norm_q, norm_d;
  logic neg_q, neg_d;
  out_item_t res_q, res_d;
  out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic signed [VAL_W-1:0] ar, ai, ar2, ai2;
  logic signed [VAL_W-1:0] opa, opb;
  logic signed [VAL_W-1:0] trunc_s, tv;
  logic [NORM_W-1:0] norm_sum;
  logic comp_esc, out_free;

  assign ar  = VAL_W'(cfg_i.a_real);
  assign ai  = VAL_W'(cfg_i.a_imag);
  assign ar2 = ar + ar;
  assign ai2 = ai + ai;

  // A component of magnitude ten or more already puts the norm at 100 or more.
  assign comp_esc = (mag(xr_q) >= ESC_COMP) || (mag(xi_q) >= ESC_COMP);

  // Products are truncated toward zero: truncate the magnitude, then sign it.
  assign trunc_s  = VAL_W'(mul_rsp_i.prod[FRAC_W +: VAL_W]);
  assign tv       = neg_q ? -trunc_s : trunc_s;
  assign norm_sum = norm_q + NORM_W'(mul_rsp_i.prod[SQ_W-1:0]);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (step_q)
      ST_XRXR: begin opa = xr_q; opb = xr_q; end
      ST_XIXI: begin opa = xi_q; opb = xi_q; end
      ST_TRTR: begin opa = tr_q; opb = tr_q; end
      ST_TITI: begin opa = ti_q; opb = ti_q; end
      ST_TRTI: begin opa = tr_q; opb = ti_q; end
      ST_SRUR: begin opa = sr_q; opb = ur_q; end
      ST_SIUI: begin opa = si_q; opb = ui_q; end
      ST_SRUI: begin opa = sr_q; opb = ui_q; end
      ST_SIUR: begin opa = si_q; opb = ur_q; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    iter_d      = iter_q;
    xr_d        = xr_q;
    xi_d        = xi_q;
    tr_d        = tr_q;
    ti_d        = ti_q;
    ur_d        = ur_q;
    ui_d        = ui_q;
    sr_d        = sr_q;
    si_d        = si_q;
    accr_d      = accr_q;
    acci_d      = acci_q;
    norm_d      = norm_q;
    neg_d       = neg_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mul_req_o.start = 1'b0;
    mul_req_o.op_a  = MUL_W'(mag(opa));
    mul_req_o.op_b  = MUL_W'(mag(opb));

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          xr_d    = VAL_W'(in_data_i.point_re);
          xi_d    = VAL_W'(in_data_i.point_im);
          iter_d  = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        // The limit is tested before the escape test.
        if (iter_q == cfg_i.max_iter) begin
          res_d.iter_count     = iter_q;
          res_d.stayed_bounded = 1'b1;
          state_d              = S_DONE;
        end else if (comp_esc) begin
          res_d.iter_count     = iter_q;
          res_d.stayed_bounded = 1'b0;
          state_d              = S_DONE;
        end else begin
          tr_d    = xr_q - ar;
          ti_d    = xi_q - ai;
          ur_d    = xr_q + ar2;
          ui_d    = xi_q + ai2;
          step_d  = ST_XRXR;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        mul_req_o.start = 1'b1;
        neg_d           = opa[VAL_W-1] ^ opb[VAL_W-1];
        state_d         = S_WAIT;
      end
      S_WAIT: begin
        if (mul_rsp_i.done) begin
          state_d = S_ISSUE;
          unique case (step_q)
            ST_XRXR: begin
              norm_d = NORM_W'(mul_rsp_i.prod[SQ_W-1:0]);
              step_d = ST_XIXI;
            end
            ST_XIXI: begin
              if (norm_sum >= ESC_NORM) begin
                res_d.iter_count     = iter_q;
                res_d.stayed_bounded = 1'b0;
                state_d              = S_DONE;
              end else begin
                step_d = ST_TRTR;
              end
            end
            ST_TRTR: begin
              sr_d   = tv;
              step_d = ST_TITI;
            end
            ST_TITI: begin
              sr_d   = sr_q - tv;
              step_d = ST_TRTI;
            end
            ST_TRTI: begin
              si_d   = tv + tv;
              step_d = ST_SRUR;
            end
            ST_SRUR: begin
              accr_d = tv;
              step_d = ST_SIUI;
            end
            ST_SIUI: begin
              accr_d = accr_q - tv;
              step_d = ST_SRUI;
            end
            ST_SRUI: begin
              acci_d = tv;
              step_d = ST_SIUR;
            end
            ST_SIUR: begin
              xr_d    = accr_q + ar;
              xi_d    = acci_q + tv + ai + ONE_FX;
              iter_d  = iter_q + ITER_W'(1);
              state_d = S_CHECK;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    iter_q <= iter_d;
    xr_q   <= xr_d;
    xi_q   <= xi_d;
    tr_q   <= tr_d;
    ti_q   <= ti_d;
    ur_q   <= ur_d;
    ui_q   <= ui_d;
    sr_q   <= sr_d;
    si_q   <= si_d;
    accr_q <= accr_d;
    acci_q <= acci_d;
    norm_q <= norm_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/cubic_julia_escape_time.sv @@
// ----------------------------------------------------------------------------
// Cubic Julia escape time
// Iterates x <- (x-a)^2 * (x+2a) + a + i in Q4.28 fixed point and counts the
// iterations until |x|^2 reaches 100 or the configured limit is met.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      in_valid_i / in_stall_o  in_item_t  (point_re, point_im)
//  out       output     out_valid_o / out_stall_i out_item_t (iter_count,
//                                                            stayed_bounded)
//  cfg       input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// Each iteration runs the limit and component test, then nine products in turn
// on the single 40 x 20 multiplier. Reset clears the sequencer state, the
// output valid flag and the registers (a = 0, max_iter = 50); no clearing
// pass is needed.
// A finished item waits in the output register, so a stalled output does not
// hold up the next item until that one finishes too.
module cubic_julia_escape_time (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cje_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cje_pkg::out_item_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [cje_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cje_pkg::CFG_W-1:0]       cfg_data_i
);
  import cje_pkg::*;

  cfg_t     cfg_q, cfg_d;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_A_REAL:   cfg_d.a_real   = cfg_data_i;
        CFG_A_IMAG:   cfg_d.a_imag   = cfg_data_i;
        CFG_MAX_ITER: cfg_d.max_iter = cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_real   <= '0;
      cfg_q.a_imag   <= '0;
      cfg_q.max_iter <= MAX_ITER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cje_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_i       (cfg_q),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp)
  );

  cje_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

endmodule

@@ rtl/cje_chk.sv @@
// ----------------------------------------------------------------------------
// Escape-time port checker
// Watches the top-level ports of the escape-time block over time.
// ----------------------------------------------------------------------------
module cje_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input cje_pkg::in_item_t             in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input cje_pkg::out_item_t            out_data_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // A stalled input item stays offered with the same value.
  a_in_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input item changed while stalled");

  // Once an item is taken, the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an item was taken");

  // The block only frees its input by handing its result to the output.
  a_free_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("input freed without a result on the output");

endmodule

bind cubic_julia_escape_time cje_chk u_cje_chk (.*);

@@ sim/cubic_julia_escape_time_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Julia escape-time testbench
// Feeds start points through the valid/stall input channel and predicts each
// escape count with an independent fixed-point model of the cubic map. A
// short directed run covers the value corners, exact norm-100 escapes and the
// zero limit. Random phases follow, each under its own constant and limit,
// while both channels idle at varying rates.
// ----------------------------------------------------------------------------
module cubic_julia_escape_time_tb;
  import cje_pkg::*;

  localparam longint unsigned FX_LIM        = 64'h4000_0000_0000_0000;
  localparam longint unsigned ESC_COMPONENT = 64'd10 << FRAC_W;
  localparam logic [127:0]    ESC_RADIUS2   = 128'd100 << (2 * FRAC_W);
  localparam longint          FX_ONE        = 64'sd1 << FRAC_W;

  localparam logic [31:0] FX_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] FX_MIN  = 32'h8000_0000;
  localparam logic [31:0] FX_SIX  = 32'h6000_0000;
  localparam logic [31:0] FX_MSIX = 32'hA000_0000;
  localparam int unsigned SPAN_TWO = 32'd1 << (FRAC_W + 1);
  localparam int unsigned SPAN_A   = 32'd5 << (FRAC_W - 2);

  localparam int          PHASES         = 9;
  localparam int          POINTS_A_PHASE = 181;
  localparam int unsigned FAST_ITER      = 31;
  localparam logic [15:0] LIMIT_TAB [PHASES] = '{16'd1, 16'd8, 16'd16, 16'd4, 16'hFFFF,
                                                 16'd12, 16'd2, 16'd20, 16'd6};

  typedef struct {
    in_item_t  point;
    out_item_t escape;
  } escape_entry_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = CFG_A_REAL;
  logic [CFG_W-1:0]      cfg_data_i = '0;

  logic signed [31:0] cfg_a_re  = '0;
  logic signed [31:0] cfg_a_im  = '0;
  logic [15:0]        cfg_limit = MAX_ITER_RST;

  in_item_t      point_q[$];
  escape_entry_t pending_escapes[$];
  logic          in_accepted = 1'b0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   n_fail = 0;

  cubic_julia_escape_time i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Any operand or sum at 2^62 or beyond marks the orbit as overflowed.
  function automatic longint fx_add(longint a, longint b, inout bit ovf);
    longint s;
    if (mag64(a) >= FX_LIM || mag64(b) >= FX_LIM) begin
      ovf = 1'b1;
      return 0;
    end
    s = a + b;
    if (mag64(s) >= FX_LIM) begin
      ovf = 1'b1;
      return 0;
    end
    return s;
  endfunction

  // Exact product of the magnitudes, truncated toward zero to 28 fraction bits.
  function automatic longint fx_mul(longint a, longint b, inout bit ovf);
    longint unsigned ma, mb;
    logic [127:0]    p;
    ma = mag64(a);
    mb = mag64(b);
    if (ma >= FX_LIM || mb >= FX_LIM) begin
      ovf = 1'b1;
      return 0;
    end
    p = ({64'd0, ma} * {64'd0, mb}) >> FRAC_W;
    if (p >= {64'd0, FX_LIM}) begin
      ovf = 1'b1;
      return 0;
    end
    return ((a < 0) != (b < 0)) ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  function automatic bit beyond_radius(longint re, longint im);
    longint unsigned mr, mi;
    logic [127:0]    norm;
    mr = mag64(re);
    mi = mag64(im);
    if (mr >= ESC_COMPONENT || mi >= ESC_COMPONENT) return 1'b1;
    norm = {64'd0, mr} * {64'd0, mr} + {64'd0, mi} * {64'd0, mi};
    return norm >= ESC_RADIUS2;
  endfunction

  function automatic out_item_t escape_time(in_item_t pt, logic signed [31:0] a_re,
                                            logic signed [31:0] a_im, logic [15:0] lim);
    longint      ar, ai, xr, xi, tr, ti, sr, si, ur, ui, qr, qi, m1, m2;
    int unsigned n;
    bit          ovf;
    out_item_t   res;
    ar  = a_re;
    ai  = a_im;
    xr  = $signed(pt.point_re);
    xi  = $signed(pt.point_im);
    n   = 0;
    ovf = 1'b0;
    while (n < lim && !ovf && !beyond_radius(xr, xi)) begin
      tr = fx_add(xr, -ar, ovf);
      ti = fx_add(xi, -ai, ovf);
      // (x - a)^2
      m1 = fx_mul(tr, tr, ovf);
      m2 = fx_mul(ti, ti, ovf);
      sr = fx_add(m1, -m2, ovf);
      m1 = fx_mul(tr, ti, ovf);
      si = fx_add(m1, m1, ovf);
      // x + 2a
      m1 = fx_add(ar, ar, ovf);
      ur = fx_add(xr, m1, ovf);
      m1 = fx_add(ai, ai, ovf);
      ui = fx_add(xi, m1, ovf);
      m1 = fx_mul(sr, ur, ovf);
      m2 = fx_mul(si, ui, ovf);
      qr = fx_add(m1, -m2, ovf);
      m1 = fx_mul(sr, ui, ovf);
      m2 = fx_mul(si, ur, ovf);
      qi = fx_add(m1, m2, ovf);
      xr = fx_add(qr, ar, ovf);
      m1 = fx_add(qi, ai, ovf);
      xi = fx_add(m1, FX_ONE, ovf);
      n++;
    end
    if (!ovf && n >= lim) begin
      res.iter_count     = lim;
      res.stayed_bounded = 1'b1;
    end else begin
      res.iter_count     = ITER_W'(n);
      res.stayed_bounded = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_fx(int unsigned span);
    longint v;
    v = longint'($urandom_range(2 * span)) - longint'(span);
    return v[31:0];
  endfunction

  function automatic logic [31:0] corner_fx();
    case ($urandom_range(4))
      0:       return FX_MAX;
      1:       return FX_MIN;
      2:       return 32'd0;
      3:       return 32'd1;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Mostly points near the interesting region, some corners, some anywhere.
  function automatic in_item_t pick_point();
    in_item_t    pt;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) begin
      pt.point_re = rand_fx(SPAN_TWO);
      pt.point_im = rand_fx(SPAN_TWO);
    end else if (r < 75) begin
      pt.point_re = $urandom_range(1) ? corner_fx() : rand_fx(SPAN_TWO);
      pt.point_im = $urandom_range(1) ? corner_fx() : rand_fx(SPAN_TWO);
    end else begin
      pt.point_re = $urandom();
      pt.point_im = $urandom();
    end
    return pt;
  endfunction

  task automatic note_fail(string msg);
    n_fail++;
    if (n_fail <= 10) $display("%s", msg);
  endtask

  task automatic queue_point(logic [31:0] re, logic [31:0] im);
    in_item_t pt;
    pt.point_re = re;
    pt.point_im = im;
    point_q.push_back(pt);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_A_REAL:   cfg_a_re = data;
      CFG_A_IMAG:   cfg_a_im = data;
      CFG_MAX_ITER: cfg_limit = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_setup(logic [31:0] a_re, logic [31:0] a_im, logic [15:0] lim);
    cfg_write(CFG_A_REAL, a_re);
    cfg_write(CFG_A_IMAG, a_im);
    cfg_write(CFG_MAX_ITER, 32'(lim));
  endtask

  // Holds the sender back until every queued point has been answered.
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (point_q.size() != 0 || in_valid_i || pending_escapes.size() != 0);
  endtask

  always @(negedge clk_i) begin : feed_blk
    if (rst_ni && (!in_valid_i || in_accepted)) begin
      if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i  <= point_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : stall_blk
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_blk
    escape_entry_t want;
    escape_entry_t seen;
    if (!rst_ni) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (pending_escapes.size() == 0) begin
          note_fail($sformatf("unexpected result: iter %0d bounded %0d",
                              out_data_o.iter_count, out_data_o.stayed_bounded));
        end else begin
          want = pending_escapes.pop_front();
          if (out_data_o.iter_count !== want.escape.iter_count ||
              out_data_o.stayed_bounded !== want.escape.stayed_bounded) begin
            note_fail($sformatf(
              "point %h/%h: expected iter %0d bounded %0d, got iter %0d bounded %0d",
              want.point.point_re, want.point.point_im, want.escape.iter_count,
              want.escape.stayed_bounded, out_data_o.iter_count,
              out_data_o.stayed_bounded));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        seen.point  = in_data_i;
        seen.escape = escape_time(in_data_i, cfg_a_re, cfg_a_im, cfg_limit);
        pending_escapes.push_back(seen);
      end
    end
  end

  initial begin : stim_blk
    in_item_t    pt;
    out_item_t   probe;
    logic [31:0] a_re, a_im;
    logic [15:0] lim;
    int          tries;
    send_idle_pct = 30;
    recv_idle_pct = 76;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: a = 0, limit 50. The origin cycles between 0 and i.
    queue_point(32'd0, 32'd0);
    queue_point(FX_MAX, FX_MAX);
    queue_point(FX_MIN, FX_MIN);
    queue_point(FX_MAX, FX_MIN);
    queue_point(FX_MIN, FX_MAX);
    // Norm of exactly 100 escapes at once; one step below it does not.
    queue_point(FX_MSIX, FX_MIN);
    queue_point(FX_MIN, FX_MSIX);
    queue_point(FX_MSIX, FX_MAX);
    queue_point(FX_SIX, FX_MAX);
    queue_point(32'd1, 32'hFFFF_FFFF);
    wait_drained();

    // A zero limit answers bounded without iterating, even for an escaping point.
    load_setup(32'd0, 32'd0, 16'd0);
    queue_point(32'd0, 32'd0);
    queue_point(FX_MIN, FX_MIN);
    wait_drained();

    load_setup(32'd0, 32'd0, 16'd1);
    queue_point(32'd0, 32'd0);
    queue_point(32'd0, FX_MAX);
    wait_drained();

    load_setup(FX_MAX, FX_MIN, 16'd3);
    queue_point(32'd0, 32'd0);
    queue_point(FX_MAX, FX_MAX);
    queue_point(32'd0, FX_MAX);
    queue_point(FX_MIN, 32'd0);
    wait_drained();

    load_setup(FX_MIN, FX_MAX, 16'd3);
    queue_point(FX_MAX, FX_MIN);
    queue_point(32'd0, 32'd0);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 3)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      lim = LIMIT_TAB[ph];
      if (ph == 2) begin
        a_re = $urandom();
        a_im = $urandom();
      end else begin
        a_re = rand_fx(SPAN_A);
        a_im = rand_fx(SPAN_A);
      end
      load_setup(a_re, a_im, lim);
      for (int k = 0; k < POINTS_A_PHASE; k++) begin
        pt = pick_point();
        // Under a huge limit only points that escape quickly keep the run short.
        if (lim > FAST_ITER) begin
          tries = 0;
          probe = escape_time(pt, a_re, a_im, 16'(FAST_ITER));
          while (probe.stayed_bounded && tries < 40) begin
            pt = pick_point();
            tries++;
            probe = escape_time(pt, a_re, a_im, 16'(FAST_ITER));
          end
          if (tries >= 40) begin
            pt.point_re = FX_MAX;
            pt.point_im = FX_MIN;
          end
        end
        point_q.push_back(pt);
      end
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog_blk
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
